// File: sv/binary_max_heap_queue_defines.svh
// Assertion macros used by the heap queue core.
`ifndef BINARY_MAX_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_DEFINES_SVH

// Checked at every rising edge outside reset.
`define HBQ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every rising edge, reset included.
`define HBQ_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// File: sv/hbq_pkg.sv
`timescale 1ns / 1ps

package hbq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = IDX_W + 2;
	localparam int KEY_W    = 32;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_EXTRACT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_EXTRACTED = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CMP,
		S_DN_LOAD,
		S_DN_CMP,
		S_WR_CUR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]         key;
		logic signed [DATA_W-1:0] data;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                     kind;
		logic [KEY_W-1:0]         key;
		logic signed [DATA_W-1:0] data;
	} item_t;

	typedef struct packed {
		status_t                  status;
		logic [KEY_W-1:0]         top_key;
		logic signed [DATA_W-1:0] top_data;
		logic [COUNT_W-1:0]       count;
	} result_t;

endpackage

// File: sv/hbq_item_if.sv
`timescale 1ns / 1ps

interface hbq_item_if import hbq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [KEY_W-1:0]         item_key;
	logic signed [DATA_W-1:0] item_data;

	modport source (output valid, kind, item_key, item_data, input ready);
	modport sink (input valid, kind, item_key, item_data, output ready);
endinterface

// File: sv/hbq_result_if.sv
`timescale 1ns / 1ps

interface hbq_result_if import hbq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [KEY_W-1:0]         top_key;
	logic signed [DATA_W-1:0] top_data;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, status, top_key, top_data, count, input ready);
	modport sink (input valid, status, top_key, top_data, count, output ready);
endinterface

// File: sv/hbq_ram.sv
`timescale 1ns / 1ps

module hbq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

// File: sv/hbq_core.sv
`timescale 1ns / 1ps
`include "binary_max_heap_queue_defines.svh"

module hbq_core import hbq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  item_t            item,
	input  logic             res_ack,
	output logic             idle,
	output logic             res_valid,
	output result_t          res,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output entry_t           wr_data,
	output logic [IDX_W-1:0] rd_addr_a,
	output logic [IDX_W-1:0] rd_addr_b,
	input  entry_t           rd_data_a,
	input  entry_t           rd_data_b
);

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   pos_q, pos_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	entry_t             cur_q, cur_d;
	entry_t             top_q, top_d;
	status_t            status_q, status_d;

	logic [IDX_W-1:0]   up_idx;
	logic [IDX_W-1:0]   cnt_up_idx;
	logic [CHILD_W-1:0] left_idx;
	logic [CHILD_W-1:0] right_idx;
	logic [CHILD_W-1:0] n_ext;
	logic               has_right;
	logic               pick_right;
	entry_t             pick;
	logic [IDX_W-1:0]   pick_idx;
	logic [CHILD_W-1:0] next_left;
	logic               up_swap;
	logic               dn_swap;
	logic               is_full;
	logic               is_empty;

	// The entry being moved stays in cur_q; only the hole position is tracked.
	assign up_idx     = (pos_q - IDX_W'(1)) >> 1;
	assign cnt_up_idx = IDX_W'((cnt_q - CNT_W'(1)) >> 1);
	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = left_idx + CHILD_W'(1);
	assign n_ext      = CHILD_W'(cnt_q);
	assign has_right  = right_idx < n_ext;
	assign pick_right = has_right && !(rd_data_a.key > rd_data_b.key);
	assign pick       = pick_right ? rd_data_b : rd_data_a;
	assign pick_idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
	assign next_left  = {1'b0, pick_idx, 1'b1};
	assign up_swap    = cur_q.key > rd_data_a.key;
	assign dn_swap    = pick.key > cur_q.key;
	assign is_full    = cnt_q == CNT_W'(CAPACITY);
	assign is_empty   = cnt_q == '0;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (item.kind == KIND_INSERT) begin
						if (is_full) begin
							state_d = S_DONE;
						end else if (is_empty) begin
							state_d = S_WR_CUR;
						end else begin
							state_d = S_UP_CMP;
						end
					end else begin
						state_d = is_empty ? S_DONE : S_DN_LOAD;
					end
				end
			end
			S_UP_CMP: begin
				if (!up_swap) begin
					state_d = S_DONE;
				end else if (up_idx == '0) begin
					state_d = S_WR_CUR;
				end
			end
			S_DN_LOAD: begin
				state_d = (cnt_q > CNT_W'(1)) ? S_DN_CMP : S_WR_CUR;
			end
			S_DN_CMP: begin
				if (!dn_swap) begin
					state_d = S_DONE;
				end else if (!(next_left < n_ext)) begin
					state_d = S_WR_CUR;
				end
			end
			S_WR_CUR: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ack) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		pos_d     = pos_q;
		cnt_d     = cnt_q;
		cur_d     = cur_q;
		top_d     = top_q;
		status_d  = status_q;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = cur_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (item.kind == KIND_INSERT) begin
						top_d = '0;
						if (is_full) begin
							status_d = STAT_FULL;
						end else begin
							status_d  = STAT_INSERTED;
							cur_d     = '{key: item.key, data: item.data};
							pos_d     = cnt_q[IDX_W-1:0];
							cnt_d     = cnt_q + CNT_W'(1);
							rd_addr_a = cnt_up_idx;
						end
					end else if (is_empty) begin
						status_d = STAT_EMPTY;
						top_d    = '{key: '0, data: '1};
					end else begin
						status_d  = STAT_EXTRACTED;
						cnt_d     = cnt_q - CNT_W'(1);
						rd_addr_a = '0;
						rd_addr_b = IDX_W'(cnt_q - CNT_W'(1));
					end
				end
			end
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (up_swap) begin
					wr_data   = rd_data_a;
					pos_d     = up_idx;
					rd_addr_a = (up_idx - IDX_W'(1)) >> 1;
				end
			end
			S_DN_LOAD: begin
				// Root goes out; the last entry is sifted down from the root.
				top_d     = rd_data_a;
				cur_d     = rd_data_b;
				pos_d     = '0;
				rd_addr_a = IDX_W'(1);
				rd_addr_b = IDX_W'(2);
			end
			S_DN_CMP: begin
				wr_en = 1'b1;
				if (dn_swap) begin
					wr_data   = pick;
					pos_d     = pick_idx;
					rd_addr_a = next_left[IDX_W-1:0];
					rd_addr_b = next_left[IDX_W-1:0] + IDX_W'(1);
				end
			end
			S_WR_CUR: begin
				wr_en = 1'b1;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		cur_q    <= cur_d;
		top_q    <= top_d;
		status_q <= status_d;
	end

	assign idle          = state_q == S_IDLE;
	assign res_valid     = state_q == S_DONE;
	assign res.status    = status_q;
	assign res.top_key   = top_q.key;
	assign res.top_data  = top_q.data;
	assign res.count     = COUNT_W'(cnt_q);

	`HBQ_ASSERT_ALWAYS(a_cnt_bound, !arst_n || cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`HBQ_ASSERT(a_no_write_idle, (state_q == S_IDLE || state_q == S_DONE) |-> !wr_en,
		"memory written outside a sift")
	`HBQ_ASSERT(a_start_idle, start |-> state_q == S_IDLE, "operation started while busy")
	`HBQ_ASSERT(a_done_hold, (state_q == S_DONE && !res_ack) |=>
		(state_q == S_DONE && $stable(cnt_q) && $stable(top_q)), "pending result changed")

endmodule

// File: sv/binary_max_heap_queue.sv
`timescale 1ns / 1ps
// Binary max-heap priority queue of up to 64 key and payload pairs.
// The req channel carries one operation per transaction: kind 0 inserts the
// pair (item_key, item_data), kind 1 extracts the entry with the largest key.
// The rsp channel returns exactly one transaction per request, in order, with
// the status, the extracted key and payload, and the entry count afterwards.
// Entries live in one dual-read, single-write memory with registered reads.
// An operation starts from idle, then each sift step visits one heap level
// (one memory read, two for an extract, and one write back per level), then
// the moving entry is written into the final hole and the result is held
// until taken. A refused insert or an extract from an empty heap goes straight to the result. The depth of
// the sift loop sets the rate; one operation is in flight at a time.
// Reset clears the entry count; the memory needs no clearing pass because
// only slots below the count are ever used.
// Results sit in an output register. While rsp is stalled, the next request is
// still taken and processed; its result waits in the core until the output
// register is free, and req.ready stays low in that time.
module binary_max_heap_queue import hbq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	hbq_item_if.sink  req,
	hbq_result_if.source rsp
);

	logic             core_idle;
	logic             res_valid;
	logic             res_ack;
	result_t          res;
	item_t            item;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic [IDX_W-1:0] rd_addr_a;
	logic [IDX_W-1:0] rd_addr_b;
	entry_t           rd_data_a;
	entry_t           rd_data_b;
	logic             out_valid_q;
	result_t          out_q;

	assign item      = '{kind: req.kind, key: req.item_key, data: req.item_data};
	assign req.ready = core_idle;
	assign res_ack   = res_valid && (!out_valid_q || rsp.ready);

	hbq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req.valid && core_idle),
		.item      (item),
		.res_ack   (res_ack),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res       (res),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	hbq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= res;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_q.status;
	assign rsp.top_key  = out_q.top_key;
	assign rsp.top_data = out_q.top_data;
	assign rsp.count    = out_q.count;

endmodule

// File: test/binary_max_heap_queue_test.sv
`timescale 1ns / 1ps

module binary_max_heap_queue_test;
	import hbq_pkg::*;

	localparam int RANDOM_OPS  = 700;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 16;

	typedef struct {
		item_t   op;
		bit      typed;
		result_t want;
	} op_row_t;

	logic clk = 1'b0;
	logic arst_n;

	hbq_item_if   item_ch();
	hbq_result_if result_ch();

	binary_max_heap_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (item_ch),
		.rsp    (result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the heap, updated once per accepted transaction.
	logic [KEY_W-1:0]         shadow_key [CAPACITY];
	logic signed [DATA_W-1:0] shadow_data [CAPACITY];
	int unsigned              shadow_fill;

	result_t     pending_results[$];
	op_row_t     directed_rows[$];
	int unsigned bad_fields;
	int unsigned ops_sent;
	int unsigned cycles;
	int unsigned hold_left;
	bit          calm;
	int unsigned n_inserted, n_refused, n_extracted, n_empty, peak_fill;

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic [KEY_W-1:0]         k;
		logic signed [DATA_W-1:0] d;
		k = shadow_key[a];
		d = shadow_data[a];
		shadow_key[a] = shadow_key[b];
		shadow_data[a] = shadow_data[b];
		shadow_key[b] = k;
		shadow_data[b] = d;
	endfunction

	function automatic result_t heap_apply(item_t op);
		result_t     r;
		int unsigned pos, parent, left, right, pick;
		bit          moving;
		r.status = STAT_INSERTED;
		r.top_key = '0;
		r.top_data = '0;
		if (op.kind == KIND_INSERT) begin
			if (shadow_fill >= CAPACITY) begin
				r.status = STAT_FULL;
				n_refused++;
			end else begin
				pos = shadow_fill;
				shadow_key[pos] = op.key;
				shadow_data[pos] = op.data;
				shadow_fill++;
				moving = 1'b1;
				while (moving && pos > 0) begin
					parent = (pos - 1) / 2;
					if (shadow_key[pos] > shadow_key[parent]) begin
						swap_slots(pos, parent);
						pos = parent;
					end else begin
						moving = 1'b0;
					end
				end
				n_inserted++;
				if (shadow_fill > peak_fill) peak_fill = shadow_fill;
			end
		end else if (shadow_fill == 0) begin
			r.status = STAT_EMPTY;
			r.top_data = -1;
			n_empty++;
		end else begin
			r.status = STAT_EXTRACTED;
			r.top_key = shadow_key[0];
			r.top_data = shadow_data[0];
			shadow_fill--;
			shadow_key[0] = shadow_key[shadow_fill];
			shadow_data[0] = shadow_data[shadow_fill];
			pos = 0;
			moving = 1'b1;
			while (moving) begin
				left = 2 * pos + 1;
				right = left + 1;
				if (left >= shadow_fill) begin
					moving = 1'b0;
				end else begin
					// On equal child keys the right child wins.
					if (right >= shadow_fill || shadow_key[left] > shadow_key[right])
						pick = left;
					else
						pick = right;
					if (shadow_key[pick] > shadow_key[pos]) begin
						swap_slots(pos, pick);
						pos = pick;
					end else begin
						moving = 1'b0;
					end
				end
			end
			n_extracted++;
		end
		r.count = COUNT_W'(shadow_fill);
		return r;
	endfunction

	function automatic void add_row(logic kind, logic [KEY_W-1:0] key,
		logic signed [DATA_W-1:0] data, bit typed, status_t st,
		logic [KEY_W-1:0] tk, logic signed [DATA_W-1:0] td, logic [COUNT_W-1:0] cnt);
		op_row_t row;
		row.op.kind = kind;
		row.op.key = key;
		row.op.data = data;
		row.typed = typed;
		row.want.status = st;
		row.want.top_key = tk;
		row.want.top_data = td;
		row.want.count = cnt;
		directed_rows.push_back(row);
	endfunction

	task automatic push_op(input item_t op, input bit typed, input result_t want);
		result_t model_res;
		while (!calm && $urandom_range(99) < 20) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= op.kind;
		item_ch.item_key <= op.key;
		item_ch.item_data <= op.data;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		model_res = heap_apply(op);
		pending_results.push_back(typed ? want : model_res);
		ops_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Receiver: a counted hold-off takes precedence over random stalls.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (calm) begin
			result_ch.ready <= 1'b1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= 20);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected: status %0d count %0d",
					result_ch.status, result_ch.count);
				bad_fields++;
			end else begin
				want = pending_results.pop_front();
				if (result_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_ch.status);
					bad_fields++;
				end
				if (result_ch.top_key !== want.top_key) begin
					$error("top_key: expected %0h, got %0h", want.top_key, result_ch.top_key);
					bad_fields++;
				end
				if (result_ch.top_data !== want.top_data) begin
					$error("top_data: expected %0d, got %0d", want.top_data,
						result_ch.top_data);
					bad_fields++;
				end
				if (result_ch.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, result_ch.count);
					bad_fields++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		item_t       op;
		result_t     blank;
		int unsigned phase, plen, insert_pct, i;
		int unsigned directed_count;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_INSERT;
		item_ch.item_key = '0;
		item_ch.item_data = '0;
		result_ch.ready = 1'b0;
		hold_left = 0;
		calm = 1'b0;
		shadow_fill = 0;
		blank = '0;

		// kind, key, data, typed, status, top_key, top_data, count
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 1, STAT_EMPTY, 32'h0, -32'sd1, 7'd0);
		add_row(KIND_INSERT, 32'hFFFFFFFF, 32'sh80000000, 1, STAT_INSERTED, 32'h0, 32'sh0, 7'd1);
		add_row(KIND_INSERT, 32'h0, 32'sh7FFFFFFF, 1, STAT_INSERTED, 32'h0, 32'sh0, 7'd2);
		add_row(KIND_INSERT, 32'h5, 32'sh0, 0, STAT_INSERTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_INSERT, 32'h5, 32'sh1, 0, STAT_INSERTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_INSERT, 32'h5, 32'sh2, 0, STAT_INSERTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_INSERT, 32'h5, 32'sh3, 0, STAT_INSERTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 1, STAT_EXTRACTED, 32'hFFFFFFFF, 32'sh80000000,
			7'd5);
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 0, STAT_EXTRACTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 0, STAT_EXTRACTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 0, STAT_EXTRACTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 0, STAT_EXTRACTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_EXTRACT, 32'hFFFFFFFF, -32'sd1, 1, STAT_EXTRACTED, 32'h0, 32'sh7FFFFFFF,
			7'd0);
		add_row(KIND_EXTRACT, 32'hFFFFFFFF, -32'sd1, 1, STAT_EMPTY, 32'h0, -32'sd1, 7'd0);
		// Alternating bit patterns; the unsigned order puts 80000000 above 55555555.
		add_row(KIND_INSERT, 32'hAAAAAAAA, 32'sh55555555, 0, STAT_INSERTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_INSERT, 32'h55555555, 32'shAAAAAAAA, 0, STAT_INSERTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_INSERT, 32'h1, -32'sd1, 0, STAT_INSERTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_INSERT, 32'h80000000, 32'sh0, 0, STAT_INSERTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 0, STAT_EXTRACTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 0, STAT_EXTRACTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 0, STAT_EXTRACTED, 32'h0, 32'sh0, 7'd0);
		add_row(KIND_EXTRACT, 32'h0, 32'sh0, 0, STAT_EXTRACTED, 32'h0, 32'sh0, 7'd0);
		directed_count = directed_rows.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			push_op(directed_rows[r].op, directed_rows[r].typed, directed_rows[r].want);
		settle();

		// Phases cycle through filling, mixed traffic and draining, so the heap
		// is driven to full and back to empty several times.
		phase = 0;
		while (ops_sent < directed_count + RANDOM_OPS) begin
			@(posedge clk);
			calm = (phase == 3);
			if (phase == 1) hold_left = HOLD_CYCLES;
			@(negedge clk);
			case (phase % 3)
				0: begin
					insert_pct = 88;
					plen = $urandom_range(140, 100);
				end
				1: begin
					insert_pct = 50;
					plen = $urandom_range(100, 60);
				end
				default: begin
					insert_pct = 12;
					plen = $urandom_range(100, 60);
				end
			endcase
			for (i = 0; i < plen && ops_sent < directed_count + RANDOM_OPS; i++) begin
				op.kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_EXTRACT;
				op.data = $urandom;
				case ($urandom_range(3))
					0: op.key = $urandom_range(7);
					1: op.key = $urandom_range(1) ? '1 : '0;
					default: op.key = $urandom;
				endcase
				push_op(op, 1'b0, blank);
			end
			settle();
			phase++;
		end

		@(posedge clk);
		calm = 1'b0;
		@(negedge clk);
		settle();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d transactions (%0d directed) in %0d phases, peak fill %0d of %0d",
			ops_sent, directed_count, phase, peak_fill, CAPACITY);
		$display("inserted %0d, refused full %0d, extracted %0d, empty extracts %0d",
			n_inserted, n_refused, n_extracted, n_empty);
		if (bad_fields == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/hbq_pkg.sv
sv/hbq_item_if.sv
sv/hbq_result_if.sv
sv/hbq_ram.sv
sv/hbq_core.sv
sv/binary_max_heap_queue.sv
test/binary_max_heap_queue_test.sv
